>>> rtl/ffa_pkg.sv
package ffa_pkg;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_FIT   = 2'd1;
	localparam logic [1:0] ST_NULL     = 2'd2;
	localparam logic [1:0] ST_REJECTED = 2'd3;

	// command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// fixed field widths
	localparam int BYTES_W = 16;
	localparam int UNIT_W  = 11;
	localparam int HB_W    = 14;
	localparam int FAIL_W  = 16;
	localparam int N_W     = 17;   // rounded request in units

	localparam int HEAP_MIN_BYTES   = 1024;
	localparam int HEAP_RESET_BYTES = 8192;

endpackage

>>> rtl/ffa_ram.sv
module ffa_ram #(
	parameter int WIDTH = 23,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/ffa_div.sv
// quotient by a constant through a reciprocal multiply: the operand is
// latched at start, quotient and remainder flag are registered the cycle after
module ffa_div #(
	parameter int DIVISOR = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [ffa_pkg::BYTES_W-1:0]         dividend,
	output logic                                done,
	output logic [ffa_pkg::BYTES_W-1:0]         quot,
	output logic                                rem_nz
);

	localparam int     W     = ffa_pkg::BYTES_W;
	localparam int     SH    = W + $clog2(DIVISOR);
	localparam longint RECIP = ((longint'(1) << SH) + longint'(DIVISOR) - longint'(1)) /
		longint'(DIVISOR);
	localparam int     RW    = W + 2;
	localparam int     PW    = W + RW;

	logic [W-1:0]  x_q;
	logic          run_q;
	logic          done_q;
	logic [W-1:0]  quot_q;
	logic          rem_nz_q;
	logic [PW-1:0] prod;
	logic [W-1:0]  q_c;
	logic [PW-1:0] back;

	// exact floor division for every W-bit operand
	assign prod = PW'(x_q) * PW'(RECIP);
	assign q_c  = W'(prod >> SH);
	assign back = PW'(q_c) * PW'(DIVISOR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			run_q  <= start;
			done_q <= run_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= dividend;
		end
		if (run_q) begin
			quot_q   <= q_c;
			rem_nz_q <= x_q != W'(back);
		end
	end

	assign done   = done_q;
	assign quot   = quot_q;
	assign rem_nz = rem_nz_q;

endmodule

>>> rtl/first_fit_heap_allocator_core.sv
// First-fit heap allocator with an address-ordered free list and coalescing.
// Command channel: an item is transferred at a clock edge with start high and
// busy low. command selects allocate (request_bytes) or free (release_unit).
// busy drops in the cycle that shows the result.
// Result channel: done is high for exactly one cycle with status,
// granted_unit, free_bytes, min_free_bytes and fail_count; the transfer
// completes at the end of that cycle, and the receiver cannot stall it.
// An allocate walks the free blocks from the head until one fits;
// the byte-to-unit conversion runs through a reciprocal multiply
// and each list hop costs a header read in the simple dual-port header RAM.
// A free walks the free blocks below the freed address.
// Configuration: heap_bytes_we writes heap_bytes; values below 1024 are
// dropped, values above the heap capacity saturate to it. A write (and reset)
// runs an init pass: S_ISTART/S_IDIV derive the unit count, then S_CLR
// clears the header RAM one entry per cycle; busy is high throughout.
// fail_count survives a heap write, the low-water mark is reset.
// After reset the heap is HEAP_UNITS*UNIT_BYTES bytes, capped at 8192.
module first_fit_heap_allocator_core #(
	parameter int HEAP_UNITS  = 1024,
	parameter int UNIT_BYTES  = 8,
	parameter int ROUND_SHIFT = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         command,
	input  logic [ffa_pkg::BYTES_W-1:0]  request_bytes,
	input  logic [ffa_pkg::UNIT_W-1:0]   release_unit,
	input  logic                         heap_bytes_we,
	input  logic [ffa_pkg::HB_W-1:0]     heap_bytes,
	output logic                         done,
	output logic [1:0]                   status,
	output logic [ffa_pkg::UNIT_W-1:0]   granted_unit,
	output logic [ffa_pkg::HB_W-1:0]     free_bytes,
	output logic [ffa_pkg::HB_W-1:0]     min_free_bytes,
	output logic [ffa_pkg::FAIL_W-1:0]   fail_count
);

	localparam int IDX_W  = $clog2(HEAP_UNITS);
	localparam int SIZE_W = $clog2(HEAP_UNITS + 1);
	localparam int N_W    = ffa_pkg::N_W;
	localparam int HB_W   = ffa_pkg::HB_W;
	localparam int UW     = ffa_pkg::UNIT_W;
	localparam int XW     = ((SIZE_W > N_W) ? SIZE_W : N_W) + 2;
	localparam int CW     = ((SIZE_W > UW) ? SIZE_W : UW) + 1;
	localparam int MAX_BYTES = HEAP_UNITS * UNIT_BYTES;
	localparam int RST_BYTES = (ffa_pkg::HEAP_RESET_BYTES < MAX_BYTES) ?
		ffa_pkg::HEAP_RESET_BYTES : MAX_BYTES;
	localparam int PW     = ((SIZE_W + 5 > HB_W) ? SIZE_W + 5 : HB_W) + 1;

	typedef struct packed {
		logic              used;
		logic              nv;
		logic [IDX_W-1:0]  nxt;
		logic [SIZE_W-1:0] size;
	} hdr_t;

	localparam int HDR_W = $bits(hdr_t);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_ISTART = 5'd1;
	localparam logic [4:0] S_IDIV   = 5'd2;
	localparam logic [4:0] S_CLR    = 5'd3;
	localparam logic [4:0] S_ADIV   = 5'd4;
	localparam logic [4:0] S_AWALK  = 5'd5;
	localparam logic [4:0] S_ACHK   = 5'd6;
	localparam logic [4:0] S_ASPLIT = 5'd7;
	localparam logic [4:0] S_ALINK  = 5'd8;
	localparam logic [4:0] S_AMARK  = 5'd9;
	localparam logic [4:0] S_FRQ    = 5'd10;
	localparam logic [4:0] S_FCHK   = 5'd11;
	localparam logic [4:0] S_FWALK  = 5'd12;
	localparam logic [4:0] S_FSTEP  = 5'd13;
	localparam logic [4:0] S_FDEC   = 5'd14;
	localparam logic [4:0] S_FNXT   = 5'd15;
	localparam logic [4:0] S_FWRP   = 5'd16;
	localparam logic [4:0] S_FPRV   = 5'd17;
	localparam logic [4:0] S_FIN    = 5'd18;

	logic [4:0]               state_q;
	logic [HB_W-1:0]          hb_q;
	logic [SIZE_W-1:0]        units_q;
	logic [IDX_W-1:0]         head_q;
	logic                     head_v_q;
	logic [SIZE_W-1:0]        used_q;
	logic [HB_W-1:0]          low_water_q;
	logic [ffa_pkg::FAIL_W-1:0] failures_q;
	logic [IDX_W-1:0]         clr_q;
	logic [IDX_W-1:0]         cur_q;
	logic                     cur_v_q;
	logic [IDX_W-1:0]         prv_q;
	logic                     has_prv_q;
	hdr_t                     prv_ent_q;
	logic [IDX_W-1:0]         p_q;
	hdr_t                     p_ent_q;
	logic [SIZE_W-1:0]        p_end_q;
	logic [N_W-1:0]           n_q;
	logic [SIZE_W-1:0]        guard_q;
	logic                     lw_upd_q;
	logic [1:0]               st_q;
	logic [UW-1:0]            gr_q;
	logic                     done_q;
	logic [HB_W-1:0]          free_q;
	logic [HB_W-1:0]          minf_q;

	// divider
	logic                       div_start;
	logic [ffa_pkg::BYTES_W-1:0] div_in;
	logic                       div_done;
	logic [ffa_pkg::BYTES_W-1:0] div_q;
	logic                       div_rnz;

	// header RAM
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	hdr_t              ram_wdata;
	logic [IDX_W-1:0]  ram_raddr;
	logic [HDR_W-1:0]  ram_rdata;
	hdr_t              rd;

	logic              accept;
	logic [N_W-1:0]    ceil_u;
	logic [N_W-1:0]    n_new;
	logic [XW-1:0]     r_wide;
	logic              split_ok;
	logic              cur_ok;
	logic [CW-1:0]     rel_p;
	logic [PW-1:0]     used_bytes;
	logic [HB_W-1:0]   fb_now;
	logic [HB_W-1:0]   lw_new;
	logic              prv_adj;
	logic              prv_ovl;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = state_q != S_IDLE;
	assign rd     = hdr_t'(ram_rdata);

	assign div_start = accept ? (command == ffa_pkg::CMD_ALLOC && request_bytes != '0)
	                          : (state_q == S_ISTART);
	assign div_in    = accept ? request_bytes : ffa_pkg::BYTES_W'(hb_q);

	ffa_div #(.DIVISOR(UNIT_BYTES)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_in),
		.done     (div_done),
		.quot     (div_q),
		.rem_nz   (div_rnz)
	);

	ffa_ram #(.WIDTH(HDR_W), .DEPTH(HEAP_UNITS)) u_hdr_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// request size in units, with header and rounding
	assign ceil_u = N_W'(div_q) + N_W'(div_rnz);
	assign n_new  = (((ceil_u + N_W'(1)) >> ROUND_SHIFT) + N_W'(1)) << ROUND_SHIFT;

	assign r_wide   = XW'(p_q) + XW'(n_q);
	assign split_ok = (XW'(p_ent_q.size) > XW'(n_q)) && (r_wide < XW'(HEAP_UNITS));

	assign cur_ok = cur_v_q && (SIZE_W'(cur_q) < units_q);
	assign rel_p  = CW'(release_unit) - CW'(1);

	assign prv_ovl = has_prv_q &&
		((SIZE_W + 1)'(prv_q) + (SIZE_W + 1)'(prv_ent_q.size) > (SIZE_W + 1)'(p_q));
	assign prv_adj =
		((SIZE_W + 1)'(prv_q) + (SIZE_W + 1)'(prv_ent_q.size) == (SIZE_W + 1)'(p_q));

	// free bytes from the used-unit count, floored at zero
	assign used_bytes = PW'(used_q) * PW'(UNIT_BYTES);
	assign fb_now = (used_bytes > PW'(hb_q)) ? '0 : HB_W'(PW'(hb_q) - used_bytes);
	assign lw_new = (lw_upd_q && fb_now < low_water_q) ? fb_now : low_water_q;

	// header RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		ram_raddr = cur_q;
		unique case (state_q)
			S_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				if (clr_q == '0) begin
					ram_wdata.size = units_q;
				end
			end
			S_ASPLIT: begin
				ram_we    = split_ok;
				ram_waddr = IDX_W'(r_wide);
				ram_wdata = '{used: 1'b0, nv: p_ent_q.nv, nxt: p_ent_q.nxt,
				              size: SIZE_W'(XW'(p_ent_q.size) - XW'(n_q))};
			end
			S_ALINK: begin
				ram_we    = has_prv_q;
				ram_waddr = prv_q;
				ram_wdata = '{used: prv_ent_q.used, nv: p_ent_q.nv,
				              nxt: p_ent_q.nxt, size: prv_ent_q.size};
			end
			S_AMARK: begin
				ram_we    = 1'b1;
				ram_waddr = p_q;
				ram_wdata = '{used: 1'b1, nv: 1'b0, nxt: '0, size: p_ent_q.size};
			end
			S_FRQ: begin
				ram_raddr = p_q;
			end
			S_FWRP: begin
				ram_we    = 1'b1;
				ram_waddr = p_q;
				ram_wdata = '{used: 1'b0, nv: p_ent_q.nv, nxt: p_ent_q.nxt,
				              size: p_ent_q.size};
			end
			S_FPRV: begin
				ram_we    = 1'b1;
				ram_waddr = prv_q;
				if (prv_adj) begin
					ram_wdata = '{used: prv_ent_q.used, nv: p_ent_q.nv, nxt: p_ent_q.nxt,
					              size: prv_ent_q.size + p_ent_q.size};
				end else begin
					ram_wdata = '{used: prv_ent_q.used, nv: 1'b1, nxt: p_q,
					              size: prv_ent_q.size};
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_ISTART;
			hb_q        <= HB_W'(RST_BYTES);
			low_water_q <= HB_W'(RST_BYTES);
			failures_q  <= '0;
			used_q      <= '0;
			head_q      <= '0;
			head_v_q    <= 1'b1;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (heap_bytes_we && int'(heap_bytes) >= ffa_pkg::HEAP_MIN_BYTES) begin
				// reinit: new size, fresh list, low-water reset
				hb_q        <= (int'(heap_bytes) > MAX_BYTES) ? HB_W'(MAX_BYTES) : heap_bytes;
				low_water_q <= (int'(heap_bytes) > MAX_BYTES) ? HB_W'(MAX_BYTES) : heap_bytes;
				used_q      <= '0;
				head_q      <= '0;
				head_v_q    <= 1'b1;
				state_q     <= S_ISTART;
			end else begin
				unique case (state_q)
					S_IDLE: begin
						if (accept) begin
							gr_q     <= '0;
							lw_upd_q <= 1'b0;
							if (command == ffa_pkg::CMD_ALLOC) begin
								if (request_bytes == '0) begin
									st_q    <= ffa_pkg::ST_NULL;
									state_q <= S_FIN;
								end else begin
									state_q <= S_ADIV;
								end
							end else if (release_unit == '0) begin
								st_q    <= ffa_pkg::ST_NULL;
								state_q <= S_FIN;
							end else if (rel_p >= CW'(units_q)) begin
								st_q    <= ffa_pkg::ST_REJECTED;
								state_q <= S_FIN;
							end else begin
								p_q     <= IDX_W'(rel_p);
								state_q <= S_FRQ;
							end
						end
					end
					S_ISTART: begin
						state_q <= S_IDIV;
					end
					S_IDIV: begin
						if (div_done) begin
							units_q <= (div_q > ffa_pkg::BYTES_W'(HEAP_UNITS)) ?
								SIZE_W'(HEAP_UNITS) : SIZE_W'(div_q);
							clr_q   <= '0;
							state_q <= S_CLR;
						end
					end
					S_CLR: begin
						clr_q <= clr_q + IDX_W'(1);
						if (clr_q == IDX_W'(HEAP_UNITS - 1)) begin
							state_q <= S_IDLE;
						end
					end
					S_ADIV: begin
						if (div_done) begin
							n_q       <= n_new;
							cur_q     <= head_q;
							cur_v_q   <= head_v_q;
							has_prv_q <= 1'b0;
							guard_q   <= '0;
							state_q   <= S_AWALK;
						end
					end
					S_AWALK: begin
						if (!cur_ok || guard_q >= SIZE_W'(HEAP_UNITS)) begin
							failures_q <= failures_q + (ffa_pkg::FAIL_W)'(1);
							st_q       <= ffa_pkg::ST_NO_FIT;
							state_q    <= S_FIN;
						end else begin
							state_q <= S_ACHK;
						end
					end
					S_ACHK: begin
						if (XW'(rd.size) >= XW'(n_q)) begin
							p_q     <= cur_q;
							p_ent_q <= rd;
							state_q <= S_ASPLIT;
						end else begin
							prv_q     <= cur_q;
							prv_ent_q <= rd;
							has_prv_q <= 1'b1;
							cur_v_q   <= rd.nv;
							cur_q     <= rd.nxt;
							guard_q   <= guard_q + SIZE_W'(1);
							state_q   <= S_AWALK;
						end
					end
					S_ASPLIT: begin
						if (split_ok) begin
							p_ent_q.size <= SIZE_W'(n_q);
							p_ent_q.nxt  <= IDX_W'(r_wide);
							p_ent_q.nv   <= 1'b1;
						end
						state_q <= S_ALINK;
					end
					S_ALINK: begin
						if (!has_prv_q) begin
							head_q   <= p_ent_q.nxt;
							head_v_q <= p_ent_q.nv;
						end
						state_q <= S_AMARK;
					end
					S_AMARK: begin
						used_q   <= used_q + SIZE_W'(n_q);
						gr_q     <= UW'((IDX_W + 1)'(p_q) + (IDX_W + 1)'(1));
						st_q     <= ffa_pkg::ST_OK;
						lw_upd_q <= 1'b1;
						state_q  <= S_FIN;
					end
					S_FRQ: begin
						state_q <= S_FCHK;
					end
					S_FCHK: begin
						if (!rd.used || rd.size == '0 ||
						    rd.size > units_q - SIZE_W'(p_q)) begin
							st_q    <= ffa_pkg::ST_REJECTED;
							state_q <= S_FIN;
						end else begin
							p_ent_q   <= rd;
							p_end_q   <= SIZE_W'(p_q) + rd.size;
							cur_q     <= head_q;
							cur_v_q   <= head_v_q;
							has_prv_q <= 1'b0;
							guard_q   <= '0;
							state_q   <= S_FWALK;
						end
					end
					S_FWALK: begin
						if (cur_ok && cur_q < p_q && guard_q < SIZE_W'(HEAP_UNITS)) begin
							state_q <= S_FSTEP;
						end else begin
							state_q <= S_FDEC;
						end
					end
					S_FSTEP: begin
						prv_q     <= cur_q;
						prv_ent_q <= rd;
						has_prv_q <= 1'b1;
						cur_v_q   <= rd.nv;
						cur_q     <= rd.nxt;
						guard_q   <= guard_q + SIZE_W'(1);
						state_q   <= S_FWALK;
					end
					S_FDEC: begin
						if ((cur_ok && SIZE_W'(cur_q) < p_end_q) || prv_ovl) begin
							// overlaps a free block: duplicate free
							st_q    <= ffa_pkg::ST_REJECTED;
							state_q <= S_FIN;
						end else begin
							used_q       <= used_q - p_ent_q.size;
							p_ent_q.used <= 1'b0;
							if (cur_ok && SIZE_W'(cur_q) == p_end_q) begin
								state_q <= S_FNXT;
							end else begin
								p_ent_q.nxt <= cur_ok ? cur_q : '0;
								p_ent_q.nv  <= cur_ok;
								state_q     <= S_FWRP;
							end
						end
					end
					S_FNXT: begin
						// absorb the free block right after
						p_ent_q.size <= p_ent_q.size + rd.size;
						p_ent_q.nxt  <= rd.nxt;
						p_ent_q.nv   <= rd.nv;
						state_q      <= S_FWRP;
					end
					S_FWRP: begin
						st_q <= ffa_pkg::ST_OK;
						if (!has_prv_q) begin
							head_q   <= p_q;
							head_v_q <= 1'b1;
							state_q  <= S_FIN;
						end else begin
							state_q <= S_FPRV;
						end
					end
					S_FPRV: begin
						state_q <= S_FIN;
					end
					S_FIN: begin
						done_q      <= 1'b1;
						free_q      <= fb_now;
						minf_q      <= lw_new;
						low_water_q <= lw_new;
						state_q     <= S_IDLE;
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	assign done           = done_q;
	assign status         = st_q;
	assign granted_unit   = gr_q;
	assign free_bytes     = free_q;
	assign min_free_bytes = minf_q;
	assign fail_count     = failures_q;

endmodule

>>> rtl/ffa_chk.sv
module ffa_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic [1:0]                   status,
	input logic [ffa_pkg::UNIT_W-1:0]   granted_unit
);

	// an accepted command always occupies the block
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not raise busy");

	// one result per command, after a busy period
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a command in progress");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_grant_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ffa_pkg::ST_OK |-> granted_unit == '0)
		else $error("unit granted on a failed command");

endmodule

bind first_fit_heap_allocator_core ffa_chk u_ffa_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.status       (status),
	.granted_unit (granted_unit)
);
